>>> src/blpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_pkg: shared definitions for the Bresenham line pixel generator
// Screen geometry, field widths, opcodes and the pixel word type.
// ----------------------------------------------------------------------------
package blpg_pkg;

  localparam int SCREEN_WIDTH = 320;

  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 17;
  localparam int ERR_W   = 11;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

endpackage

`default_nettype wire

>>> src/bresenham_line_pixel_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator: integer line walker for a frame buffer
// A load word (opcode 0) sets up a line from two endpoints and a color and
// produces no output. Each step word (opcode 1) produces one frame-buffer
// write, address = row * 320 + column (mod 2^17), with the last pixel
// flagged; a step with no active line produces nothing. One word is taken
// per clock while in_stall is low: the whole step (address multiply-add, error
// update, end compare) is one level of logic between the line registers and
// the output register, and a one-entry skid register lets the input keep
// flowing while the output is stalled, until the skid entry is full. Each
// pixel is registered in the output or skid register. No clipping is done.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator (
  input  wire logic                            clk,
  input  wire logic                            rst,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            opcode,
  input  wire logic [blpg_pkg::COL_W-1:0]      start_x,
  input  wire logic [blpg_pkg::ROW_W-1:0]      start_y,
  input  wire logic [blpg_pkg::COL_W-1:0]      end_x,
  input  wire logic [blpg_pkg::ROW_W-1:0]      end_y,
  input  wire logic [blpg_pkg::COLOR_W-1:0]    line_color,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [blpg_pkg::ADDR_W-1:0]          pixel_address,
  output logic [blpg_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                 pixel_last
);

  localparam int CW = blpg_pkg::COL_W;
  localparam int RW = blpg_pkg::ROW_W;
  localparam int EW = blpg_pkg::ERR_W;
  localparam int AW = blpg_pkg::ADDR_W;

  // line state
  logic                          line_active;
  logic                          steep_mode;
  logic [CW-1:0]                 current_col;
  logic [RW-1:0]                 current_row;
  logic [CW-1:0]                 major_end;
  logic                          minor_step_negative;
  logic [CW-1:0]                 major_span;
  logic [CW-1:0]                 minor_span;
  logic signed [EW-1:0]          error_term;
  logic [blpg_pkg::COLOR_W-1:0]  held_color;

  // result pipe
  blpg_pkg::pixel_t out_word;
  blpg_pkg::pixel_t skid_word;
  logic             skid_valid;

  logic             accept;
  logic             is_load;
  logic             emit;
  blpg_pkg::pixel_t new_word;

  // load setup
  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic [CW-1:0]        adx;
  logic [CW-1:0]        ady;
  logic                 load_steep;
  logic                 swap;
  logic [CW-1:0]        o_sx;
  logic [RW-1:0]        o_sy;
  logic [CW-1:0]        o_ex;
  logic [RW-1:0]        o_ey;
  logic signed [CW:0]   minor_delta;
  logic [CW-1:0]        load_major_span;
  logic [CW-1:0]        load_major_end;
  logic [CW-1:0]        load_minor_span;

  // step
  logic [CW-1:0]        major_pos;
  logic                 at_end;
  logic [CW-1:0]        col_next;
  logic [RW-1:0]        row_next;
  logic signed [EW-1:0] error_next;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign is_load  = (opcode == blpg_pkg::OP_LOAD);
  assign emit     = accept && !is_load && line_active;

  always_comb begin
    dx         = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy         = $signed({2'b00, end_y}) - $signed({2'b00, start_y});
    adx        = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady        = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    load_steep = !(ady < adx);
    swap       = load_steep ? (start_y > end_y) : (start_x > end_x);
    o_sx       = swap ? end_x : start_x;
    o_sy       = swap ? end_y : start_y;
    o_ex       = swap ? start_x : end_x;
    o_ey       = swap ? start_y : end_y;
    if (load_steep) begin
      load_major_span = CW'(o_ey - o_sy);
      load_major_end  = CW'(o_ey);
      minor_delta     = $signed({1'b0, o_ex}) - $signed({1'b0, o_sx});
    end else begin
      load_major_span = o_ex - o_sx;
      load_major_end  = o_ex;
      minor_delta     = $signed({2'b00, o_ey}) - $signed({2'b00, o_sy});
    end
    load_minor_span = minor_delta[CW] ? CW'(-minor_delta) : minor_delta[CW-1:0];
  end

  always_comb begin
    major_pos = steep_mode ? CW'(current_row) : current_col;
    at_end    = (major_pos == major_end);
    col_next  = current_col;
    row_next  = current_row;
    if (error_term > 0) begin
      if (steep_mode) begin
        col_next = minor_step_negative ? current_col - 1'b1 : current_col + 1'b1;
      end else begin
        row_next = minor_step_negative ? current_row - 1'b1 : current_row + 1'b1;
      end
      error_next = error_term
                 + EW'({minor_span, 1'b0})
                 - EW'({major_span, 1'b0});
    end else begin
      error_next = error_term + EW'({minor_span, 1'b0});
    end
    if (steep_mode) begin
      row_next = current_row + 1'b1;
    end else begin
      col_next = current_col + 1'b1;
    end
    new_word.address = AW'(AW'(current_row) * AW'(blpg_pkg::SCREEN_WIDTH))
                     + AW'(current_col);
    new_word.color   = held_color;
    new_word.last    = at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active         <= 1'b0;
      steep_mode          <= 1'b0;
      current_col         <= '0;
      current_row         <= '0;
      major_end           <= '0;
      minor_step_negative <= 1'b0;
      major_span          <= '0;
      minor_span          <= '0;
      error_term          <= '0;
      held_color          <= '0;
    end else if (accept) begin
      if (is_load) begin
        line_active         <= 1'b1;
        steep_mode          <= load_steep;
        current_col         <= o_sx;
        current_row         <= o_sy;
        major_end           <= load_major_end;
        minor_step_negative <= minor_delta[CW];
        major_span          <= load_major_span;
        minor_span          <= load_minor_span;
        error_term          <= EW'({load_minor_span, 1'b0}) - EW'(load_major_span);
        held_color          <= line_color;
      end else if (line_active) begin
        if (at_end) begin
          line_active <= 1'b0;
        end else begin
          current_col <= col_next;
          current_row <= row_next;
          error_term  <= error_next;
        end
      end
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= emit;
      end else begin
        out_valid  <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= new_word;
      end else begin
        out_word  <= new_word;
      end
    end else if (emit) begin
      skid_word <= new_word;
    end
  end

  assign pixel_address = out_word.address;
  assign pixel_color   = out_word.color;
  assign pixel_last    = out_word.last;

endmodule

`default_nettype wire

>>> src/blpg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blpg_checker: port-level checks for the Bresenham line pixel generator
// Watches both handshakes and the output word over time.
// ----------------------------------------------------------------------------
module blpg_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            opcode,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [blpg_pkg::ADDR_W-1:0]     pixel_address,
  input wire logic [blpg_pkg::COLOR_W-1:0]    pixel_color,
  input wire logic                            pixel_last
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_address)
      && $stable(pixel_color) && $stable(pixel_last))
    else $error("stalled output word changed");

  // drop all output after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // stall input only behind a held output word
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no output pending");

  // a load into an empty pipe produces no word
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == blpg_pkg::OP_LOAD && !out_valid
      |=> !out_valid)
    else $error("load word produced a pixel");

endmodule

bind bresenham_line_pixel_generator blpg_checker u_blpg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .opcode        (opcode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .pixel_address (pixel_address),
  .pixel_color   (pixel_color),
  .pixel_last    (pixel_last)
);

`default_nettype wire
